// ===== rtl/core/lbrm_pkg.sv =====
// Package for the latency bucket ring monitor: request and result item types,
// the command passed from the front end to the back end, and shared constants.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package lbrm_pkg;

	localparam int TIME_W       = 64;
	localparam int LAT_W        = 32;
	localparam int BKT_CNT_W    = 6;
	localparam int FUNC_W       = 2;

	localparam int RING_SIZE_DEF = 32;
	localparam int BUCKET_US_DEF = 1000000;

	localparam int QDEPTH       = 2;

	localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_END   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [TIME_W-1:0] now_us;
		logic [TIME_W-1:0] after_us;
	} req_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]    bkt_start_us;
		logic [LAT_W-1:0]     total_latency_us;
		logic [LAT_W-1:0]     worst_latency_us;
		logic [LAT_W-1:0]     event_count;
		logic [BKT_CNT_W-1:0] bucket_count;
		logic                 is_summary;
		logic                 last;
	} res_item_t;

	typedef enum logic [1:0] {
		CMD_START,
		CMD_END,
		CMD_READ
	} cmd_op_t;

	// For start and end the value is the bucket start time, for read the filter time.
	typedef struct packed {
		cmd_op_t           op;
		logic [TIME_W-1:0] value;
		logic [LAT_W-1:0]  lat;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] bucket_start;
		logic [LAT_W-1:0]  sum;
		logic [LAT_W-1:0]  worst;
		logic [LAT_W-1:0]  events;
	} ring_entry_t;

endpackage

// ===== rtl/core/lbrm_front.sv =====
// Front end of the latency bucket ring monitor: accepts requests, keeps the start
// time, measures latency and finds the bucket start by reciprocal multiplication.
// Depends on lbrm_pkg.
`timescale 1ns / 1ps

module lbrm_front
	import lbrm_pkg::*;
#(
	parameter int BUCKET_US = BUCKET_US_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      cmd_valid,
	input  logic      cmd_ready,
	output cmd_t      cmd
);

	localparam int HALF_W = TIME_W / 2;
	localparam logic [TIME_W-1:0] RECIP   = {TIME_W{1'b1}} / TIME_W'(BUCKET_US);
	localparam logic [HALF_W-1:0] RECIP_H = HALF_W'(RECIP >> HALF_W);
	localparam logic [HALF_W-1:0] RECIP_L = HALF_W'(RECIP);
	localparam logic [HALF_W-1:0] DIV_X1  = HALF_W'(BUCKET_US);
	localparam logic [HALF_W-1:0] DIV_X2  = DIV_X1 << 1;

	// The estimated quotient is at most two below the true one, so the first
	// remainder lies below three bucket widths and two folding steps finish it.
	typedef enum logic [3:0] {
		F_IDLE,
		F_MUL_HH,
		F_MUL_HL,
		F_MUL_LH,
		F_QUOT,
		F_BACK,
		F_REM,
		F_FOLD,
		F_FIN
	} front_state_t;

	front_state_t          state_q;
	logic                  cmd_vld_q;
	cmd_t                  cmd_q;
	logic [TIME_W-1:0]     start_time_q;
	cmd_op_t               op_q;
	logic [TIME_W-1:0]     now_q;
	logic [LAT_W-1:0]      lat_q;
	logic [TIME_W-1:0]     hi_q;
	logic [TIME_W-1:0]     mid_q;
	logic [HALF_W-1:0]     qlo_q;
	logic [HALF_W-1:0]     prod_lo_q;
	logic [HALF_W-1:0]     rem_q;
	logic [HALF_W-1:0]     mul_a;
	logic [HALF_W-1:0]     mul_b;
	logic [TIME_W-1:0]     mul_p;
	logic [HALF_W-1:0]     rem_fin;

	assign req_ready = (state_q == F_IDLE) && !cmd_vld_q;
	assign cmd_valid = cmd_vld_q;
	assign cmd       = cmd_q;

	always_comb begin
		mul_a = now_q[TIME_W-1:HALF_W];
		mul_b = RECIP_H;
		case (state_q)
			F_MUL_HL: begin
				mul_b = RECIP_L;
			end
			F_MUL_LH: begin
				mul_a = now_q[HALF_W-1:0];
			end
			F_BACK: begin
				mul_a = qlo_q;
				mul_b = DIV_X1;
			end
			default: begin
			end
		endcase
		mul_p   = mul_a * mul_b;
		rem_fin = (rem_q >= DIV_X1) ? rem_q - DIV_X1 : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			cmd_vld_q    <= 1'b0;
			start_time_q <= '0;
		end else begin
			if (cmd_vld_q && cmd_ready) begin
				cmd_vld_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (req_valid && req_ready) begin
						case (req.func)
							FUNC_START: begin
								start_time_q <= req.now_us;
								op_q         <= CMD_START;
								now_q        <= req.now_us;
								state_q      <= F_MUL_HH;
							end
							FUNC_END: begin
								if (start_time_q != '0) begin
									lat_q   <= LAT_W'(req.now_us - start_time_q);
									op_q    <= CMD_END;
									now_q   <= req.now_us;
									state_q <= F_MUL_HH;
								end
							end
							FUNC_READ: begin
								cmd_q.op    <= CMD_READ;
								cmd_q.value <= req.after_us;
								cmd_q.lat   <= '0;
								cmd_vld_q   <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				F_MUL_HH: begin
					hi_q    <= mul_p;
					state_q <= F_MUL_HL;
				end
				F_MUL_HL: begin
					mid_q   <= mul_p;
					state_q <= F_MUL_LH;
				end
				F_MUL_LH: begin
					mid_q   <= mid_q + mul_p;
					state_q <= F_QUOT;
				end
				F_QUOT: begin
					qlo_q   <= hi_q[HALF_W-1:0] + mid_q[TIME_W-1:HALF_W];
					state_q <= F_BACK;
				end
				F_BACK: begin
					prod_lo_q <= mul_p[HALF_W-1:0];
					state_q   <= F_REM;
				end
				F_REM: begin
					rem_q   <= now_q[HALF_W-1:0] - prod_lo_q;
					state_q <= F_FOLD;
				end
				F_FOLD: begin
					if (rem_q >= DIV_X2) begin
						rem_q <= rem_q - DIV_X2;
					end
					state_q <= F_FIN;
				end
				F_FIN: begin
					cmd_q.op    <= op_q;
					cmd_q.value <= now_q - TIME_W'(rem_fin);
					cmd_q.lat   <= lat_q;
					cmd_vld_q   <= 1'b1;
					state_q     <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/lbrm_queue.sv =====
// Command queue of the latency bucket ring monitor: a short first-in first-out
// buffer between the front end and the back end.
// Depends on lbrm_pkg.
`timescale 1ns / 1ps

module lbrm_queue
	import lbrm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/lbrm_back.sv =====
// Back end of the latency bucket ring monitor: holds the bucket ring in a memory,
// updates the current bucket and walks the ring to produce result items.
// Depends on lbrm_pkg.
`timescale 1ns / 1ps

module lbrm_back
	import lbrm_pkg::*;
#(
	parameter int RING_SIZE = RING_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	localparam int IDX_W  = $clog2(RING_SIZE);
	localparam int WALK_W = $clog2(RING_SIZE + 1);

	typedef enum logic {
		B_IDLE,
		B_WALK
	} back_state_t;

	back_state_t           state_q;
	ring_entry_t           ring_mem_q [RING_SIZE];
	logic [RING_SIZE-1:0]  valid_q;
	ring_entry_t           cur_q;
	logic [IDX_W-1:0]      cur_idx_q;
	logic [TIME_W-1:0]     since_q;
	logic [WALK_W-1:0]     walk_n_q;
	logic [IDX_W-1:0]      walk_idx_q;
	logic [BKT_CNT_W-1:0]  cnt_q;
	logic                  rd_vld_s1;
	logic                  rd_bit_s1;
	ring_entry_t           rd_data_s1;
	res_item_t             res_q;
	logic                  res_valid_q;

	logic                  take;
	logic                  hit;
	logic [IDX_W-1:0]      new_idx;
	ring_entry_t           upd;
	logic                  wr_en;
	logic                  out_free;
	logic                  qual;
	logic                  adv;
	logic                  issue;
	logic                  fin;
	logic                  res_load;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(RING_SIZE - 1)) ? '0 : i + 1'b1;
	endfunction

	assign cmd_ready = state_q == B_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		take    = cmd_valid && cmd_ready;
		hit     = cur_q.bucket_start == cmd.value;
		new_idx = hit ? cur_idx_q : next_idx(cur_idx_q);
		if (hit) begin
			upd = cur_q;
		end else begin
			upd              = '0;
			upd.bucket_start = cmd.value;
		end
		if (cmd.op == CMD_END) begin
			upd.sum    = upd.sum + cmd.lat;
			upd.worst  = (cmd.lat > upd.worst) ? cmd.lat : upd.worst;
			upd.events = upd.events + 1'b1;
		end
		wr_en = take && (cmd.op != CMD_READ);

		out_free = !res_valid_q || res_ready;
		qual     = rd_vld_s1 && rd_bit_s1 && (rd_data_s1.bucket_start != '0)
			&& ((since_q == '0) || (rd_data_s1.bucket_start > since_q));
		adv      = (state_q == B_WALK) && (!qual || out_free);
		issue    = adv && (walk_n_q != WALK_W'(RING_SIZE));
		fin      = (state_q == B_WALK) && !rd_vld_s1
			&& (walk_n_q == WALK_W'(RING_SIZE)) && out_free;
		res_load = (adv && qual) || fin;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem_q[new_idx] <= upd;
		end
		if (issue) begin
			rd_data_s1 <= ring_mem_q[walk_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_q     <= '0;
			cur_q       <= '0;
			cur_idx_q   <= '0;
			walk_n_q    <= '0;
			walk_idx_q  <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_bit_s1   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (wr_en) begin
						cur_q            <= upd;
						cur_idx_q        <= new_idx;
						valid_q[new_idx] <= 1'b1;
					end
					if (take && (cmd.op == CMD_READ)) begin
						since_q    <= cmd.value;
						walk_n_q   <= '0;
						walk_idx_q <= next_idx(cur_idx_q);
						cnt_q      <= '0;
						rd_vld_s1  <= 1'b0;
						state_q    <= B_WALK;
					end
				end
				B_WALK: begin
					if (adv) begin
						rd_vld_s1 <= issue;
						if (issue) begin
							rd_bit_s1  <= valid_q[walk_idx_q];
							walk_n_q   <= walk_n_q + 1'b1;
							walk_idx_q <= next_idx(walk_idx_q);
						end
						if (qual) begin
							res_q.bkt_start_us     <= rd_data_s1.bucket_start;
							res_q.total_latency_us <= rd_data_s1.sum;
							res_q.worst_latency_us <= rd_data_s1.worst;
							res_q.event_count      <= rd_data_s1.events;
							res_q.bucket_count     <= '0;
							res_q.is_summary       <= 1'b0;
							res_q.last             <= 1'b0;
							cnt_q                  <= cnt_q + 1'b1;
						end
					end
					if (fin) begin
						res_q.bkt_start_us     <= '0;
						res_q.total_latency_us <= '0;
						res_q.worst_latency_us <= '0;
						res_q.event_count      <= '0;
						res_q.bucket_count     <= cnt_q;
						res_q.is_summary       <= 1'b1;
						res_q.last             <= 1'b1;
						state_q                <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/latency_bucket_ring_monitor_core.sv =====
// Top level of the latency bucket ring monitor: front end, command queue and back end.
// Depends on lbrm_pkg, lbrm_front, lbrm_queue and lbrm_back.
`timescale 1ns / 1ps

// A start request records its timestamp and an end request adds the latency since
// that start to the current time bucket; a read request returns one result per
// tagged bucket starting after its filter time (every tagged bucket for a zero filter),
// oldest first, then a summary result with the bucket count. Start and end requests
// hold the front end through the bucket start calculation: a reciprocal
// multiplication on one 32 by 32 bit multiplier, then a subtraction and two remainder
// correction steps. A read walks the ring memory through its single read port, one
// entry per cycle unless the output stalls, while further requests wait. Up to two
// commands wait between the front and back ends. The ring comes out of reset empty
// without a clearing pass.
module latency_bucket_ring_monitor_core
	import lbrm_pkg::*;
#(
	parameter int RING_SIZE = RING_SIZE_DEF,
	parameter int BUCKET_US = BUCKET_US_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic b_valid;
	logic b_ready;
	cmd_t b_cmd;

	lbrm_front #(
		.BUCKET_US(BUCKET_US)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	lbrm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_cmd    (b_cmd)
	);

	lbrm_back #(
		.RING_SIZE(RING_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd       (b_cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

`ifndef SYNTHESIS
	a_bucket_tagged: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.is_summary |->
			res.bkt_start_us != '0 && res.bucket_count == '0 && !res.last)
		else $error("bucket result carries an untagged bucket or summary fields");

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_summary |->
			res.last && res.bkt_start_us == '0 && res.total_latency_us == '0
			&& res.worst_latency_us == '0 && res.event_count == '0)
		else $error("summary result carries bucket data");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_summary |-> res.bucket_count <= BKT_CNT_W'(RING_SIZE))
		else $error("summary counts more buckets than the ring holds");
`endif

endmodule
